// ----- rtl/core/cfd_pkg.sv -----
// package for the cobs frame decoder core
// holds widths, status codes and the result beat type shared by all core modules
`default_nettype none
package cfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CAP_W  = 13;
  localparam int unsigned CNT_W  = 13;

  localparam logic [CAP_W-1:0]  MAX_CAPACITY = 13'd4096;
  localparam logic [CAP_W-1:0]  CAP_RESET    = 13'd64;
  localparam logic [BYTE_W-1:0] BYTE_ZERO    = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_FF      = 8'hFF;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_ZERO  = 2'd2
  } status_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_EOF  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    status_t           status;
    logic [CNT_W-1:0]  length;
    logic              last;
  } result_t;

  typedef struct packed {
    logic    data_vld;
    logic    eof_vld;
    result_t data_res;
    result_t eof_res;
  } push_t;

endpackage
`default_nettype wire

// ----- rtl/core/cfd_decode.sv -----
// per-byte cobs decode step with frame state registers
// depends on cfd_pkg; produces up to two result beats per accepted byte
`default_nettype none
module cfd_decode (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic [cfd_pkg::BYTE_W-1:0] byte_in,
  input  wire logic                       last_in,
  input  wire logic [cfd_pkg::CAP_W-1:0]  capacity,
  output cfd_pkg::push_t                  push
);

  logic [cfd_pkg::BYTE_W-1:0] remain_r, remain_nxt;
  logic                       owed_r, owed_nxt;
  logic [cfd_pkg::CNT_W-1:0]  count_r, count_nxt;
  cfd_pkg::status_t           status_r, status_nxt;

  logic [cfd_pkg::CAP_W-1:0]  cap;
  logic                       full;
  cfd_pkg::status_t           rep_status;

  assign cap  = (capacity < cfd_pkg::MAX_CAPACITY) ? capacity : cfd_pkg::MAX_CAPACITY;
  assign full = (count_r >= cap);

  always_comb begin
    remain_nxt = remain_r;
    owed_nxt   = owed_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    rep_status = cfd_pkg::ST_OK;

    push.data_vld        = 1'b0;
    push.data_res.kind   = cfd_pkg::KIND_DATA;
    push.data_res.data   = byte_in;
    push.data_res.status = cfd_pkg::ST_OK;
    push.data_res.length = '0;
    push.data_res.last   = ~last_in;
    push.eof_vld         = 1'b0;
    push.eof_res.kind    = cfd_pkg::KIND_EOF;
    push.eof_res.data    = cfd_pkg::BYTE_ZERO;
    push.eof_res.status  = cfd_pkg::ST_OK;
    push.eof_res.length  = '0;
    push.eof_res.last    = 1'b1;

    if (status_r == cfd_pkg::ST_OK) begin
      if (remain_r != '0) begin
        if (full) begin
          status_nxt = cfd_pkg::ST_TRUNC;
        end else begin
          push.data_vld = 1'b1;
          count_nxt     = count_r + 1'b1;
          remain_nxt    = remain_r - 1'b1;
        end
      end else begin
        if (owed_r) begin
          if (full) begin
            status_nxt = cfd_pkg::ST_TRUNC;
          end else begin
            push.data_vld      = 1'b1;
            push.data_res.data = cfd_pkg::BYTE_ZERO;
            count_nxt          = count_r + 1'b1;
          end
          owed_nxt = 1'b0;
        end
        if (status_nxt == cfd_pkg::ST_OK) begin
          if (byte_in == cfd_pkg::BYTE_ZERO) begin
            status_nxt = cfd_pkg::ST_ZERO;
          end else begin
            remain_nxt = byte_in - 1'b1;
            owed_nxt   = (byte_in != cfd_pkg::BYTE_FF);
          end
        end
      end
    end

    if (last_in) begin
      rep_status = status_nxt;
      if (status_nxt == cfd_pkg::ST_OK && remain_nxt != '0) begin
        rep_status = cfd_pkg::ST_TRUNC;
      end
      push.eof_vld        = 1'b1;
      push.eof_res.status = rep_status;
      push.eof_res.length = (rep_status == cfd_pkg::ST_OK) ? count_nxt : '0;
      remain_nxt = '0;
      owed_nxt   = 1'b0;
      count_nxt  = '0;
      status_nxt = cfd_pkg::ST_OK;
    end

    if (!accept) begin
      push.data_vld = 1'b0;
      push.eof_vld  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r <= '0;
      owed_r   <= 1'b0;
      count_r  <= '0;
      status_r <= cfd_pkg::ST_OK;
    end else if (accept) begin
      remain_r <= remain_nxt;
      owed_r   <= owed_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/cfd_outq.sv -----
// result queue of the cobs frame decoder, two beats in and one beat out per cycle
// depends on cfd_pkg; registered entries feed the output port directly
`default_nettype none
module cfd_outq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfd_pkg::push_t push,
  output logic             room,
  output logic             valid,
  input  wire logic        pop,
  output cfd_pkg::result_t head
);

  cfd_pkg::result_t               entry_r [cfd_pkg::Q_DEPTH];
  logic [cfd_pkg::Q_PTR_W-1:0]    wptr_r, wptr_nxt;
  logic [cfd_pkg::Q_PTR_W-1:0]    rptr_r, rptr_nxt;
  logic [cfd_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [cfd_pkg::Q_PTR_W-1:0]    eof_ptr;
  logic                           do_pop;

  assign valid   = (cnt_r != '0);
  assign room    = (cnt_r <= cfd_pkg::Q_CNT_W'(cfd_pkg::Q_DEPTH - 2));
  assign head    = entry_r[rptr_r];
  assign do_pop  = pop & valid;
  assign eof_ptr = push.data_vld ? wptr_r + 1'b1 : wptr_r;

  always_comb begin
    wptr_nxt = wptr_r + cfd_pkg::Q_PTR_W'(push.data_vld) + cfd_pkg::Q_PTR_W'(push.eof_vld);
    rptr_nxt = rptr_r + cfd_pkg::Q_PTR_W'(do_pop);
    cnt_nxt  = cnt_r + cfd_pkg::Q_CNT_W'(push.data_vld) + cfd_pkg::Q_CNT_W'(push.eof_vld)
               - cfd_pkg::Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.data_vld) begin
      entry_r[wptr_r] <= push.data_res;
    end
    if (push.eof_vld) begin
      entry_r[eof_ptr] <= push.eof_res;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/cobs_frame_decoder_core.sv -----
// top level of the cobs frame decoder: capacity register, decode step, result queue
// depends on cfd_pkg, cfd_decode and cfd_outq
//
//   port group | direction | handshake          | payload
//   in_        | input     | in_valid/in_stall   | in_byte, in_last
//   out_       | output    | out_valid/out_stall | out_kind, out_byte, out_code, out_length, out_last
//   cfg_       | input     | cfg_valid/cfg_ready | cfg_data (output_capacity)
//
// one encoded byte per cycle while in_stall is low; a byte yields zero, one or two result beats
// results are written into the result queue when their byte is taken, one beat per cycle leaves while out_stall is low
// a four-entry result queue sets the rate: in_stall rises while fewer than two slots are free
// a byte that yields two beats (a decoded byte plus frame report) takes two queue slots, sent out one after the other
// synchronous active-low reset clears frame state and queue, capacity returns to 64
`default_nettype none
module cobs_frame_decoder_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [cfd_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                       in_last,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_kind,
  output logic [cfd_pkg::BYTE_W-1:0]      out_byte,
  output logic [1:0]                      out_code,
  output logic [cfd_pkg::CNT_W-1:0]       out_length,
  output logic                            out_last,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [cfd_pkg::CAP_W-1:0]  cfg_data
);

  logic [cfd_pkg::CAP_W-1:0] cap_r;
  logic                      room;
  logic                      accept;
  cfd_pkg::push_t            push;
  cfd_pkg::result_t          head;

  assign cfg_ready = 1'b1;
  assign in_stall  = ~room;
  assign accept    = in_valid & room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= cfd_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  cfd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .byte_in  (in_byte),
    .last_in  (in_last),
    .capacity (cap_r),
    .push     (push)
  );

  cfd_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .room  (room),
    .valid (out_valid),
    .pop   (~out_stall),
    .head  (head)
  );

  assign out_kind   = head.kind;
  assign out_byte   = head.data;
  assign out_code   = head.status;
  assign out_length = head.length;
  assign out_last   = head.last;

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// self-checking testbench for cobs_frame_decoder_core: directed frames, then random
// well-formed, broken and noise frames over several capacity settings, with random idling
// depends on cfd_pkg and the rtl of cobs_frame_decoder_core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_BYTES = 195;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum int {IDLE_NONE, IDLE_RANDOM, IDLE_SPARSE} idle_mode_t;
  typedef logic [BYTE_W-1:0] octet_t;
  typedef octet_t octet_q[$];

  typedef struct {
    octet_t      data;
    logic        fin;
    int unsigned gap;
    logic        drain;
  } enc_byte_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  in_byte = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_kind;
  logic [BYTE_W-1:0]  out_byte;
  logic [1:0]         out_code;
  logic [CNT_W-1:0]   out_length;
  logic               out_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CAP_W-1:0]   cfg_data = '0;

  // decoder state as seen by the prediction
  logic [CAP_W-1:0]   cap_reg = CAP_RESET;
  logic [BYTE_W-1:0]  blk_left = '0;
  logic               zero_owed = 1'b0;
  logic [CNT_W-1:0]   dec_cnt = '0;
  status_t            frame_st = ST_OK;

  enc_byte_t   pending_bytes[$];
  result_t     expected_beats[$];
  result_t     want;
  enc_byte_t   nxt;
  idle_mode_t  tx_mode = IDLE_RANDOM;
  idle_mode_t  rx_mode = IDLE_RANDOM;
  int unsigned tx_wait = 0;
  logic        tx_armed = 1'b0;
  int unsigned rx_wait = 0;
  int          hold_trigger = 0;
  int          hold_seen = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned bytes_in = 0;
  int unsigned beats_out = 0;
  int unsigned frames = 0;
  int unsigned frames_bad = 0;
  int unsigned cfg_writes = 0;

  cobs_frame_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_code  (out_code),
    .out_length(out_length),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned draw_gap(idle_mode_t m);
    case (m)
      IDLE_NONE: return 0;
      IDLE_RANDOM: return $urandom_range(0, 15);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    endcase
  endfunction

  // expected result beats for one accepted encoded byte
  function automatic void decode_byte(input octet_t b, input logic fin);
    logic [CAP_W-1:0] lim;
    status_t          st;
    result_t          r;
    result_t          beats[$];
    lim = (cap_reg < MAX_CAPACITY) ? cap_reg : MAX_CAPACITY;
    if (frame_st == ST_OK) begin
      r = '0;
      r.kind = KIND_DATA;
      if (blk_left != 0) begin
        if (dec_cnt >= lim) begin
          frame_st = ST_TRUNC;
        end else begin
          r.data = b;
          beats.push_back(r);
          dec_cnt++;
          blk_left--;
        end
      end else begin
        if (zero_owed) begin
          if (dec_cnt >= lim) begin
            frame_st = ST_TRUNC;
          end else begin
            r.data = BYTE_ZERO;
            beats.push_back(r);
            dec_cnt++;
          end
          zero_owed = 1'b0;
        end
        if (frame_st == ST_OK) begin
          if (b == BYTE_ZERO) begin
            frame_st = ST_ZERO;
          end else begin
            blk_left = b - 8'd1;
            zero_owed = (b != BYTE_FF);
          end
        end
      end
    end
    if (fin) begin
      st = frame_st;
      if (st == ST_OK && blk_left != 0) st = ST_TRUNC;
      r = '0;
      r.kind = KIND_EOF;
      r.status = st;
      r.length = (st == ST_OK) ? dec_cnt : '0;
      beats.push_back(r);
      frames++;
      if (st != ST_OK) frames_bad++;
      blk_left = '0;
      zero_owed = 1'b0;
      dec_cnt = '0;
      frame_st = ST_OK;
    end
    if (beats.size() > 0) beats[beats.size() - 1].last = 1'b1;
    foreach (beats[i]) expected_beats.push_back(beats[i]);
  endfunction

  function automatic void check_field(input string name, input logic [CNT_W-1:0] exp_v,
                                      input logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0d got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic octet_q cobs_encode(input octet_q raw);
    octet_q enc;
    octet_q blk;
    foreach (raw[i]) begin
      if (raw[i] == BYTE_ZERO) begin
        enc.push_back(octet_t'(blk.size() + 1));
        foreach (blk[j]) enc.push_back(blk[j]);
        blk.delete();
      end else begin
        blk.push_back(raw[i]);
        if (blk.size() == 254) begin
          enc.push_back(BYTE_FF);
          foreach (blk[j]) enc.push_back(blk[j]);
          blk.delete();
        end
      end
    end
    enc.push_back(octet_t'(blk.size() + 1));
    foreach (blk[j]) enc.push_back(blk[j]);
    return enc;
  endfunction

  task automatic queue_frame(input octet_q enc, input logic drain_first);
    enc_byte_t it;
    foreach (enc[i]) begin
      it.data = enc[i];
      it.fin = (i == enc.size() - 1);
      it.gap = draw_gap(tx_mode);
      it.drain = drain_first && (i == 0);
      pending_bytes.push_back(it);
    end
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_reg = v;
    cfg_writes++;
  endtask

  // input side
  always @(posedge clk) begin : tx_side
    logic vld_nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      vld_nxt = in_valid;
      if (in_valid && !in_stall) begin
        decode_byte(in_byte, in_last);
        bytes_in++;
        vld_nxt = 1'b0;
      end
      if (!vld_nxt && pending_bytes.size() > 0) begin
        if (!tx_armed) begin
          tx_wait = pending_bytes[0].gap;
          tx_armed = 1'b1;
        end
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (!pending_bytes[0].drain || expected_beats.size() == 0) begin
          nxt = pending_bytes.pop_front();
          in_byte <= nxt.data;
          in_last <= nxt.fin;
          vld_nxt = 1'b1;
          tx_armed = 1'b0;
        end
      end
      in_valid <= vld_nxt;
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out++;
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: kind %0d byte %0d", out_kind, out_byte);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          check_field("out_kind", CNT_W'(want.kind), CNT_W'(out_kind));
          check_field("out_byte", CNT_W'(want.data), CNT_W'(out_byte));
          check_field("out_code", CNT_W'(want.status), CNT_W'(out_code));
          check_field("out_length", want.length, out_length);
          check_field("out_last", CNT_W'(want.last), CNT_W'(out_last));
        end
        rx_wait = draw_gap(rx_mode);
      end
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        rx_wait = HOLD_CYCLES;
      end
      out_stall <= (rx_wait != 0);
      if (rx_wait != 0) rx_wait--;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CAP_W-1:0] cap_plan[6];
    octet_q           raw;
    octet_q           enc;
    int unsigned      phase_bytes;
    int unsigned      sel;
    int unsigned      len;
    int unsigned      cut;
    logic             first;
    cap_plan = '{13'd8191, 13'd0, 13'd4096, 13'd1, 13'd13, CAP_RESET};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // single code byte, data extremes with owed zero, zero code, short block, owed zero dropped
    queue_frame('{8'h01}, 1'b0);
    queue_frame('{8'h03, 8'hFF, 8'h00, 8'h02, 8'h80}, 1'b0);
    queue_frame('{8'h02, 8'hAA, 8'h00, 8'h55}, 1'b0);
    queue_frame('{8'h05, 8'h01, 8'h02}, 1'b0);
    queue_frame('{8'h02, 8'h41, 8'h01}, 1'b0);
    queue_frame('{8'h00}, 1'b0);
    wait_idle();
    // owed zero at capacity, data beyond capacity
    write_capacity(13'd2);
    queue_frame('{8'h03, 8'h11, 8'h22, 8'h02, 8'h33}, 1'b0);
    queue_frame('{8'h04, 8'h11, 8'h22, 8'h33}, 1'b0);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_capacity(p < 6 ? cap_plan[p] : CAP_W'($urandom_range(2, 100)));
      tx_mode = idle_mode_t'(p % 3);
      rx_mode <= idle_mode_t'((p + 1) % 3);
      if (p == 2) begin
        tx_mode = IDLE_NONE;
        hold_trigger <= hold_trigger + 1;
      end
      phase_bytes = 0;
      first = 1'b1;
      if (p == 0) begin
        raw.delete();
        len = 254 + $urandom_range(0, 10);
        for (int k = 0; k < len; k++) raw.push_back(octet_t'($urandom_range(1, 255)));
        enc = cobs_encode(raw);
        queue_frame(enc, 1'b0);
        phase_bytes += enc.size();
      end
      while (phase_bytes < PHASE_BYTES) begin
        raw.delete();
        sel = $urandom_range(0, 99);
        len = (sel < 45) ? $urandom_range(0, 8) :
              (sel < 85) ? $urandom_range(9, 30) :
              (sel < 98) ? $urandom_range(31, 80) : $urandom_range(250, 300);
        for (int k = 0; k < len; k++)
          raw.push_back(($urandom_range(0, 5) == 0) ? BYTE_ZERO
                                                    : octet_t'($urandom_range(1, 255)));
        enc = cobs_encode(raw);
        sel = $urandom_range(0, 99);
        if (sel >= 94) begin
          enc.delete();
          len = $urandom_range(1, 12);
          for (int k = 0; k < len; k++) enc.push_back(octet_t'($urandom_range(0, 255)));
        end else if (sel >= 88) begin
          enc[$urandom_range(0, enc.size() - 1)] = octet_t'($urandom_range(0, 255));
        end else if (sel >= 80) begin
          enc[$urandom_range(0, enc.size() - 1)] = BYTE_ZERO;
        end else if (sel >= 70 && enc.size() > 1) begin
          cut = $urandom_range(1, enc.size() - 1);
          while (enc.size() > cut) void'(enc.pop_back());
        end
        queue_frame(enc, first || ($urandom_range(0, 29) == 0));
        first = 1'b0;
        phase_bytes += enc.size();
      end
    end

    while (pending_bytes.size() != 0 || in_valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_beats.size());
      errors++;
    end
    $display("run: %0d frames (%0d with bad status), %0d encoded bytes, %0d result beats",
             frames, frames_bad, bytes_in, beats_out);
    $display("run: %0d capacity writes, %0d cycles, %0d mismatches",
             cfg_writes, cycles, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
